FILE: sv/sram_bank_conflict_counter_top_defines.svh
// Assertion macros for the bank conflict counter.
`ifndef SRAM_BANK_CONFLICT_COUNTER_TOP_DEFINES_SVH
`define SRAM_BANK_CONFLICT_COUNTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SBCC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sbcc assertion failed");
`define SBCC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("sbcc assertion failed");
`else
`define SBCC_ASSERT_ALWAYS(label, clk, rst, expr)
`define SBCC_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

FILE: sv/sbcc_pkg.sv
// Package with constants and types of the bank conflict counter.
package sbcc_pkg;
   localparam int MAX_WORDS_DEF = 64;
   localparam int MAX_BANKS_DEF = 32;
   localparam int ADDR_BITS     = 24;
   localparam int NBYTES_W      = 7;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int BT_W          = 16;
   localparam int FACTOR_W      = 7;
   localparam int HIT_W         = 6;
   localparam int UTIL_W        = 16;
   localparam int FRAC_BITS     = 15;
   localparam int DIVD_W        = BT_W + FRAC_BITS;
   localparam int DIVS_W        = CSR_DATA_W + FACTOR_W;
   localparam int MAX_BW        = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BANK_WIDTH = 2'd0,
      CSR_NUM_BANKS  = 2'd1,
      CSR_PEAK       = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_STORE,
      ST_CMP_STORE,
      ST_NEW_WORD,
      ST_BANK_UPD,
      ST_SCAN_RD,
      ST_SCAN_ACC,
      ST_DEN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;
endpackage

FILE: sv/sbcc_if.sv
// Request and response channel interfaces of the bank conflict counter.
interface sbcc_req_if import sbcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ADDR_BITS-1:0] byte_offset;
   logic [NBYTES_W-1:0]  access_bytes;
   logic                 last_access;
   modport source (output valid, byte_offset, access_bytes, last_access, input ready);
   modport sink (input valid, byte_offset, access_bytes, last_access, output ready);
endinterface

interface sbcc_rsp_if import sbcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FACTOR_W-1:0] conflict_factor;
   logic [HIT_W-1:0]    banks_hit;
   logic [UTIL_W-1:0]   utilisation_q15;
   logic                utilisation_valid;
   logic                store_overflow;
   modport source (output valid, conflict_factor, banks_hit, utilisation_q15,
                   utilisation_valid, store_overflow, input ready);
   modport sink (input valid, conflict_factor, banks_hit, utilisation_q15,
                 utilisation_valid, store_overflow, output ready);
endinterface

FILE: sv/sram_bank_conflict_counter_top.sv
// Top level of the shared memory bank conflict counter.
//
//   Channel  Dir  Handshake      Carries
//   req_if   in   valid/ready    byte_offset, access_bytes, last_access
//   rsp_if   out  valid/ready    conflict_factor, banks_hit, utilisation, flags
//   csr_*    in   csr_we         register index and write data
//
// A request is taken in the idle state; for each bank word it touches, the word store RAM is read
// and compared for each stored word searched, then the bank count is updated, after a new-word step if the word is new.
// A last request then scans the bank count RAM bank by bank (read, then accumulate), forms the
// factor, forms the divisor product, runs the serial divider when the peak is nonzero
// and loads the response. Reset is synchronous; bank counts are cleared by valid flops.
// A waiting response holds the next report in its final state, which stalls the requests.
`include "sram_bank_conflict_counter_top_defines.svh"
module sram_bank_conflict_counter_top import sbcc_pkg::*; #(
   parameter int MAX_WORDS = MAX_WORDS_DEF,
   parameter int MAX_BANKS = MAX_BANKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   sbcc_req_if.sink              req_if,
   sbcc_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW     = $clog2(MAX_WORDS);
   localparam int FW     = $clog2(MAX_WORDS + 1);
   localparam int BI     = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
   localparam int BCW    = $clog2(MAX_BANKS + 1);
   localparam int NB_MAX = $clog2(MAX_BANKS + 1) - 1;
   localparam int CW     = $clog2(MAX_WORDS + 1);

   state_type state_ff, state_in;

   logic [2:0]            bw_cfg_ff, nb_cfg_ff;
   logic [CSR_DATA_W-1:0] peak_ff;

   logic [2:0]            bw_ff, bw_in, nb_ff, nb_in;
   logic [ADDR_BITS-1:0]  first_ff, first_in;
   logic [7:0]            nwords_ff, nwords_in, k_ff, k_in;
   logic                  last_ff, last_in;
   logic [FW-1:0]         fill_ff, fill_in, scan_ff, scan_in;
   logic [BT_W-1:0]       bt_ff, bt_in;
   logic                  ovf_ff, ovf_in;
   logic [BI-1:0]         bank_ff, bank_in;
   logic [MAX_BANKS-1:0]  bvalid_ff, bvalid_in;
   logic [BCW-1:0]        bscan_ff, bscan_in;
   logic [CW-1:0]         max_ff, max_in;
   logic [6:0]            hit_ff, hit_in;
   logic [DIVS_W-1:0]     den_ff, den_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [UTIL_W-1:0]     util_ff, util_in;

   logic                  rv_ff, rv_in;
   logic [FACTOR_W-1:0]   r_factor_ff, r_factor_in;
   logic [HIT_W-1:0]      r_hit_ff, r_hit_in;
   logic [UTIL_W-1:0]     r_util_ff, r_util_in;
   logic                  r_uvalid_ff, r_uvalid_in;
   logic                  r_ovf_ff, r_ovf_in;

   logic [ADDR_BITS-1:0]  word_cur;
   logic [BI-1:0]         bank_cur;
   logic                  st_we, bk_we;
   logic [AW-1:0]         st_raddr;
   logic [ADDR_BITS-1:0]  st_rdata;
   logic [BI-1:0]         bk_raddr;
   logic [CW-1:0]         bk_rdata, bk_cnt;
   logic                  div_start, div_done;
   logic [DIVD_W-1:0]     div_dividend, div_q;
   logic                  req_fire;
   logic [2:0]            req_bw, req_nb;
   logic [5:0]            word_ofs;
   logic [7:0]            span;
   logic [BT_W:0]         bt_sum;
   logic [BT_W-1:0]       num_base;
   logic                  report_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_cfg_ff <= 3'd3;
         nb_cfg_ff <= 3'd4;
         peak_ff   <= CSR_DATA_W'(128);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BANK_WIDTH: bw_cfg_ff <= csr_wdata[2:0];
            CSR_NUM_BANKS:  nb_cfg_ff <= csr_wdata[2:0];
            CSR_PEAK:       peak_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   sbcc_ram #(.WIDTH(ADDR_BITS), .DEPTH(MAX_WORDS), .AW(AW)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (word_cur),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   sbcc_ram #(.WIDTH(CW), .DEPTH(MAX_BANKS), .AW(BI)) u_banks (
      .clock (clock),
      .we    (bk_we),
      .waddr (bank_ff),
      .wdata (bk_cnt + 1'b1),
      .raddr (bk_raddr),
      .rdata (bk_rdata)
   );

   sbcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_bw   = (bw_cfg_ff > 3'(MAX_BW)) ? 3'(MAX_BW) : bw_cfg_ff;
   assign req_nb   = (nb_cfg_ff > 3'(NB_MAX)) ? 3'(NB_MAX) : nb_cfg_ff;
   assign word_ofs = req_if.byte_offset[5:0] & ~(6'h3f << req_bw);
   assign span     = 8'(({2'b00, word_ofs} + {1'b0, req_if.access_bytes} - 8'd1) >> req_bw);
   assign bt_sum   = {1'b0, bt_ff} + (BT_W + 1)'(req_if.access_bytes);
   assign word_cur = (first_ff + ADDR_BITS'(k_ff)) & ({ADDR_BITS{1'b1}} >> bw_ff);
   assign bank_cur = word_cur[BI-1:0] & ~({BI{1'b1}} << nb_ff);
   assign bk_cnt   = bvalid_ff[bank_ff] ? bk_rdata : '0;
   assign num_base = (bt_ff > BT_W'(peak_ff)) ? bt_ff : BT_W'(peak_ff);
   assign div_dividend = {num_base, FRAC_BITS'(0)};
   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      bw_in       = bw_ff;
      nb_in       = nb_ff;
      first_in    = first_ff;
      nwords_in   = nwords_ff;
      k_in        = k_ff;
      last_in     = last_ff;
      fill_in     = fill_ff;
      scan_in     = scan_ff;
      bt_in       = bt_ff;
      ovf_in      = ovf_ff;
      bank_in     = bank_ff;
      bvalid_in   = bvalid_ff;
      bscan_in    = bscan_ff;
      max_in      = max_ff;
      hit_in      = hit_ff;
      den_in      = den_ff;
      factor_in   = factor_ff;
      util_in     = util_ff;
      st_we       = 1'b0;
      bk_we       = 1'b0;
      st_raddr    = scan_ff[AW-1:0];
      bk_raddr    = (state_ff == ST_SCAN_RD) ? bscan_ff[BI-1:0] : bank_cur;
      div_start   = 1'b0;
      report_load = 1'b0;
      rv_in       = rv_ff && !rsp_if.ready;
      r_factor_in = r_factor_ff;
      r_hit_in    = r_hit_ff;
      r_util_in   = r_util_ff;
      r_uvalid_in = r_uvalid_ff;
      r_ovf_in    = r_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               bw_in     = req_bw;
               nb_in     = req_nb;
               first_in  = req_if.byte_offset >> req_bw;
               nwords_in = span + 8'd1;
               k_in      = '0;
               scan_in   = '0;
               last_in   = req_if.last_access;
               bscan_in  = '0;
               max_in    = '0;
               hit_in    = '0;
               if (req_if.access_bytes == '0) begin
                  state_in = req_if.last_access ? ST_SCAN_RD : ST_IDLE;
               end else begin
                  bt_in    = bt_sum[BT_W] ? {BT_W{1'b1}} : bt_sum[BT_W-1:0];
                  state_in = (fill_ff == '0) ? ST_NEW_WORD : ST_RD_STORE;
               end
            end
         end
         ST_RD_STORE: begin
            state_in = ST_CMP_STORE;
         end
         ST_CMP_STORE: begin
            if (st_rdata == word_cur) begin
               state_in = ST_BANK_UPD;
            end else if (scan_ff + 1'b1 == fill_ff) begin
               state_in = ST_NEW_WORD;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_RD_STORE;
            end
         end
         ST_NEW_WORD: begin
            if (fill_ff >= FW'(MAX_WORDS)) begin
               ovf_in = 1'b1;
            end else begin
               st_we   = 1'b1;
               fill_in = fill_ff + 1'b1;
               bank_in = bank_cur;
            end
            scan_in  = FW'(MAX_WORDS);
            state_in = ST_BANK_UPD;
         end
         ST_BANK_UPD: begin
            if (scan_ff == FW'(MAX_WORDS) && !ovf_ff && !(fill_ff > FW'(MAX_WORDS))) begin
               bk_we = !(fill_ff == FW'(MAX_WORDS) && ovf_in && st_we);
            end
            if (k_ff + 8'd1 == nwords_ff) begin
               state_in = last_ff ? ST_SCAN_RD : ST_IDLE;
            end else begin
               k_in     = k_ff + 8'd1;
               scan_in  = '0;
               state_in = (fill_in == '0) ? ST_NEW_WORD : ST_RD_STORE;
            end
            if (bk_we) begin
               bvalid_in[bank_ff] = 1'b1;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_ACC;
         end
         ST_SCAN_ACC: begin
            if (bvalid_ff[bscan_ff[BI-1:0]] && bk_rdata != '0) begin
               hit_in = hit_ff + 7'd1;
               if (bk_rdata > max_ff) begin
                  max_in = bk_rdata;
               end
            end
            if (bscan_ff + 1'b1 == BCW'(MAX_BANKS)) begin
               state_in = ST_DEN;
            end else begin
               bscan_in = bscan_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_DEN: begin
            if (max_ff == '0) begin
               factor_in = FACTOR_W'(1);
            end else if (max_ff > CW'(127)) begin
               factor_in = FACTOR_W'(127);
            end else begin
               factor_in = FACTOR_W'(max_ff);
            end
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            den_in = DIVS_W'(peak_ff * factor_ff);
            if (peak_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               util_in  = (div_q > DIVD_W'(32768)) ? UTIL_W'(32768) : div_q[UTIL_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rv_ff || rsp_if.ready) begin
               report_load = 1'b1;
               rv_in       = 1'b1;
               r_factor_in = factor_ff;
               r_hit_in    = hit_ff[HIT_W-1:0];
               r_uvalid_in = (peak_ff != '0);
               r_util_in   = (peak_ff == '0) ? '0 : util_ff;
               r_ovf_in    = ovf_ff;
               fill_in     = '0;
               bt_in       = '0;
               ovf_in      = 1'b0;
               bvalid_in   = '0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bt_ff     <= '0;
         ovf_ff    <= 1'b0;
         bvalid_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bt_ff     <= bt_in;
         ovf_ff    <= ovf_in;
         bvalid_ff <= bvalid_in;
         rv_ff     <= rv_in;
      end
      bw_ff       <= bw_in;
      nb_ff       <= nb_in;
      first_ff    <= first_in;
      nwords_ff   <= nwords_in;
      k_ff        <= k_in;
      last_ff     <= last_in;
      scan_ff     <= scan_in;
      bank_ff     <= bank_in;
      bscan_ff    <= bscan_in;
      max_ff      <= max_in;
      hit_ff      <= hit_in;
      den_ff      <= den_in;
      factor_ff   <= factor_in;
      util_ff     <= util_in;
      r_factor_ff <= r_factor_in;
      r_hit_ff    <= r_hit_in;
      r_util_ff   <= r_util_in;
      r_uvalid_ff <= r_uvalid_in;
      r_ovf_ff    <= r_ovf_in;
   end

   assign rsp_if.valid             = rv_ff;
   assign rsp_if.conflict_factor   = r_factor_ff;
   assign rsp_if.banks_hit         = r_hit_ff;
   assign rsp_if.utilisation_q15   = r_util_ff;
   assign rsp_if.utilisation_valid = r_uvalid_ff;
   assign rsp_if.store_overflow    = r_ovf_ff;

   `SBCC_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FW'(MAX_WORDS))
   `SBCC_ASSERT_ALWAYS(a_ovf_full, clock, reset, !ovf_ff || fill_ff == FW'(MAX_WORDS))
   `SBCC_ASSERT_NEXT(a_clear_after_report, clock, reset, report_load, fill_ff == '0 && bvalid_ff == '0 && rv_ff)
   `SBCC_ASSERT_ALWAYS(a_div_done_wait, clock, reset, !div_done || state_ff == ST_DIV_WAIT)
endmodule

FILE: sv/sbcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/sbcc_div.sv
// Restoring divider producing one quotient bit per cycle.
module sbcc_div import sbcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);
   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W:0]   trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIVS_W'(trial - {1'b0, divisor}) : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_in;
endmodule

FILE: test/tb_top.sv
// Testbench for the shared memory bank conflict counter with predictor and response checker.
module tb_top;
   import sbcc_pkg::*;

   typedef struct packed {
      logic [FACTOR_W-1:0] conflict_factor;
      logic [HIT_W-1:0]    banks_hit;
      logic [UTIL_W-1:0]   utilisation_q15;
      logic                utilisation_valid;
      logic                store_overflow;
   } report_type;

   typedef struct {
      logic [ADDR_BITS-1:0] byte_offset;
      logic [NBYTES_W-1:0]  access_bytes;
      logic                 last_access;
      bit                   typed;
      report_type           report;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BANK_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sbcc_req_if req_ch();
   sbcc_rsp_if rsp_ch();

   sram_bank_conflict_counter_top DUT (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #(12 * 20000000);
      $display("Test completed with failures");
      $finish;
   end

   // Model of the block's state and registers.
   logic [ADDR_BITS-1:0] seen_words[MAX_WORDS_DEF];
   int unsigned seen_fill;
   int unsigned bank_cnt[MAX_BANKS_DEF];
   int unsigned byte_sum;
   bit          ovf_seen;
   int unsigned cfg_bw = 3, cfg_nb = 4, cfg_peak = 128;

   report_type reports_due[$];
   int         errors = 0;
   bit         no_idle = 0;
   int         rsp_hold = 0;

   function automatic void clear_cycle();
      seen_fill = 0;
      byte_sum = 0;
      ovf_seen = 0;
      foreach (bank_cnt[b]) bank_cnt[b] = 0;
   endfunction

   function automatic void touch_word(logic [ADDR_BITS-1:0] w, int unsigned bank);
      for (int i = 0; i < seen_fill; i++)
         if (seen_words[i] == w) return;
      if (seen_fill >= MAX_WORDS_DEF) begin
         ovf_seen = 1;
         return;
      end
      seen_words[seen_fill] = w;
      seen_fill++;
      bank_cnt[bank]++;
   endfunction

   function automatic bit count_access(input logic [ADDR_BITS-1:0] off,
                                       input logic [NBYTES_W-1:0] nbytes, input logic last,
                                       output report_type r);
      int unsigned bw, nbk, factor, hit;
      longint unsigned first, word_ofs, nwords, wmask, num, q;
      bw = cfg_bw > MAX_BW ? MAX_BW : cfg_bw;
      nbk = cfg_nb;
      factor = 0;
      hit = 0;
      r = '0;
      while (nbk > 0 && (1 << nbk) > MAX_BANKS_DEF) nbk--;
      if (nbytes != 0) begin
         wmask = (64'd1 << (ADDR_BITS - bw)) - 1;
         first = off >> bw;
         word_ofs = off & ((64'd1 << bw) - 1);
         nwords = ((word_ofs + nbytes - 1) >> bw) + 1;
         byte_sum += nbytes;
         if (byte_sum > 65535) byte_sum = 65535;
         for (longint unsigned k = 0; k < nwords; k++)
            touch_word(ADDR_BITS'((first + k) & wmask),
                       int'((first + k) & wmask & ((64'd1 << nbk) - 1)));
      end
      if (!last) return 0;
      foreach (bank_cnt[b]) begin
         if (bank_cnt[b] != 0) hit++;
         if (bank_cnt[b] > factor) factor = bank_cnt[b];
      end
      if (factor == 0) factor = 1;
      if (factor > 127) factor = 127;
      if (cfg_peak != 0) begin
         num = 64'(byte_sum > cfg_peak ? byte_sum : cfg_peak) * 32768;
         q = num / (64'(cfg_peak) * factor);
         r.utilisation_q15 = q > 32768 ? 16'd32768 : UTIL_W'(q);
         r.utilisation_valid = 1;
      end
      r.conflict_factor = FACTOR_W'(factor);
      r.banks_hit = HIT_W'(hit);
      r.store_overflow = ovf_seen;
      clear_cycle();
      return 1;
   endfunction

   task automatic send_request(input row_type row);
      report_type r;
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.byte_offset <= row.byte_offset;
      req_ch.access_bytes <= row.access_bytes;
      req_ch.last_access <= row.last_access;
      do @(posedge clock); while (!req_ch.ready);
      if (count_access(row.byte_offset, row.access_bytes, row.last_access, r))
         reports_due = {reports_due, (row.typed ? row.report : r)};
   endtask

   task automatic send_access(input logic [ADDR_BITS-1:0] off, input int nbytes,
                              input logic last);
      row_type row;
      row.byte_offset = off;
      row.access_bytes = NBYTES_W'(nbytes);
      row.last_access = last;
      row.typed = 0;
      row.report = '0;
      send_request(row);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BANK_WIDTH: cfg_bw = value & 7;
         CSR_NUM_BANKS:  cfg_nb = value & 7;
         default:        cfg_peak = value & 13'h1FFF;
      endcase
   endtask

   task automatic random_cycles(input int n_items);
      logic [ADDR_BITS-1:0] base, off;
      int len, nbytes, pick;
      logic last;
      while (n_items > 0) begin
         base = ADDR_BITS'($urandom);
         len = $urandom_range(1, 12);
         no_idle = ($urandom_range(0, 5) == 0);
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            off = (pick < 70) ? base + ADDR_BITS'($urandom_range(0, 1023)) : ADDR_BITS'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 10) nbytes = 0;
            else if (pick < 92) nbytes = $urandom_range(1, 16);
            else if (pick < 97) nbytes = $urandom_range(17, 64);
            else nbytes = $urandom_range(65, 127);
            last = (i == len - 1) || ($urandom_range(0, 19) == 0);
            send_access(off, nbytes, last);
            n_items--;
         end
      end
   endtask

   // Response side: random stall before each response, or a long hold when asked.
   initial begin
      int n;
      forever begin
         n = rsp_hold > 0 ? rsp_hold : (no_idle ? 0 : $urandom_range(0, 11));
         rsp_hold = 0;
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (reports_due.size() == 0) begin
            $error("response with no request pending");
            errors++;
         end else begin
            want = reports_due.pop_front();
            if (rsp_ch.conflict_factor !== want.conflict_factor) begin
               $error("conflict_factor expected %0d actual %0d", want.conflict_factor,
                      rsp_ch.conflict_factor);
               errors++;
            end
            if (rsp_ch.banks_hit !== want.banks_hit) begin
               $error("banks_hit expected %0d actual %0d", want.banks_hit, rsp_ch.banks_hit);
               errors++;
            end
            if (rsp_ch.utilisation_q15 !== want.utilisation_q15) begin
               $error("utilisation_q15 expected %0d actual %0d", want.utilisation_q15,
                      rsp_ch.utilisation_q15);
               errors++;
            end
            if (rsp_ch.utilisation_valid !== want.utilisation_valid) begin
               $error("utilisation_valid expected %0b actual %0b", want.utilisation_valid,
                      rsp_ch.utilisation_valid);
               errors++;
            end
            if (rsp_ch.store_overflow !== want.store_overflow) begin
               $error("store_overflow expected %0b actual %0b", want.store_overflow,
                      rsp_ch.store_overflow);
               errors++;
            end
         end
      end
   end

   row_type directed[$];

   initial begin
      directed = '{
         '{24'h000000, 7'd0,   1'b1, 1'b1, '{7'd1, 6'd0, 16'd32768, 1'b1, 1'b0}},
         '{24'h000000, 7'd64,  1'b1, 1'b1, '{7'd1, 6'd8, 16'd32768, 1'b1, 1'b0}},
         '{24'hFFFFFF, 7'd64,  1'b0, 1'b0, '0},
         '{24'h000000, 7'd1,   1'b1, 1'b0, '0},
         '{24'h123457, 7'd127, 1'b0, 1'b0, '0},
         '{24'hABCDEF, 7'd0,   1'b1, 1'b0, '0},
         '{24'h000008, 7'd8,   1'b0, 1'b0, '0},
         '{24'h00000C, 7'd2,   1'b0, 1'b0, '0},
         '{24'h000008, 7'd8,   1'b1, 1'b1, '{7'd1, 6'd1, 16'd32768, 1'b1, 1'b0}},
         '{24'h000000, 7'd1,   1'b0, 1'b0, '0},
         '{24'h000080, 7'd1,   1'b0, 1'b0, '0},
         '{24'h000100, 7'd1,   1'b1, 1'b1, '{7'd3, 6'd1, 16'd10922, 1'b1, 1'b0}},
         '{24'h000000, 7'd127, 1'b0, 1'b0, '0},
         '{24'h000400, 7'd127, 1'b0, 1'b0, '0},
         '{24'h000800, 7'd127, 1'b0, 1'b0, '0},
         '{24'h000C00, 7'd127, 1'b0, 1'b0, '0},
         '{24'h001000, 7'd127, 1'b1, 1'b0, '0},
         '{24'h555555, 7'd33,  1'b0, 1'b0, '0},
         '{24'hAAAAAA, 7'd64,  1'b1, 1'b0, '0}
      };
      clear_cycle();
      req_ch.valid <= 1'b0;
      req_ch.byte_offset <= '0;
      req_ch.access_bytes <= '0;
      req_ch.last_access <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i]);
      drain();

      // Long hold on the response side while requests keep coming.
      rsp_hold = 3000;
      random_cycles(100);
      drain();

      write_csr(CSR_BANK_WIDTH, 0);
      write_csr(CSR_NUM_BANKS, 0);
      write_csr(CSR_PEAK, 1);
      random_cycles(80);
      drain();

      write_csr(CSR_BANK_WIDTH, 6);
      write_csr(CSR_NUM_BANKS, 5);
      write_csr(CSR_PEAK, 4096);
      random_cycles(80);
      drain();

      // Out-of-range geometry with utilisation disabled.
      write_csr(CSR_BANK_WIDTH, 7);
      write_csr(CSR_NUM_BANKS, 7);
      write_csr(CSR_PEAK, 0);
      random_cycles(80);
      drain();

      // One bank of 64-byte words.
      write_csr(CSR_NUM_BANKS, 0);
      write_csr(CSR_PEAK, 4096);
      random_cycles(70);
      drain();

      write_csr(CSR_BANK_WIDTH, 2);
      write_csr(CSR_NUM_BANKS, 3);
      write_csr(CSR_PEAK, $urandom_range(1, 8191));
      random_cycles(70);
      drain();

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
